/* sv/mqmf_pkg.sv */
// Shared types, sizes and codes for the multi-queue message FIFO.
package mqmf_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int SLOTS      = 16;
  localparam int MAX_BYTES  = 128;

  localparam int QW  = $clog2(NUM_QUEUES);     // queue index bits
  localparam int SW  = $clog2(SLOTS);          // slot index bits
  localparam int BW  = $clog2(MAX_BYTES);      // byte index bits within a slot
  localparam int OW  = $clog2(MAX_BYTES + 1);  // byte count bits (0..MAX_BYTES)
  localparam int LAW = QW + SW;                // length store address bits
  localparam int BAW = QW + SW + BW;           // byte store address bits

  localparam int LEN_DEPTH  = 2 ** LAW;
  localparam int BYTE_DEPTH = 2 ** BAW;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] queue;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    logic [7:0] msg_len;
    logic       end_of_msg;
    logic       can_read;
  } res_t;

  // Result of the control stage, less the byte that the store returns from its registered read.
  typedef struct packed {
    status_t    status;
    logic       rd_byte;
    logic [7:0] msg_len;
    logic       end_of_msg;
    logic       can_read;
  } meta_t;

  typedef struct packed {
    logic           we;
    logic [BAW-1:0] waddr;
    logic [7:0]     wdata;
    logic           re;
    logic [BAW-1:0] raddr;
  } byte_req_t;

  typedef struct packed {
    logic           we;
    logic [LAW-1:0] waddr;
    logic [OW-1:0]  wdata;
    logic           re;
    logic [LAW-1:0] raddr;
  } len_req_t;

endpackage

/* sv/mqmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mqmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mqmf_ctrl.sv */
// Per-queue ring indices and offsets, op decode and store addressing.
module mqmf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  mqmf_pkg::cmd_t              cmd,
  input  logic [mqmf_pkg::OW-1:0]     len_rdata,
  output mqmf_pkg::byte_req_t         byte_req,
  output mqmf_pkg::len_req_t          len_req,
  output mqmf_pkg::meta_t             meta
);

  logic [mqmf_pkg::SW-1:0] write_slot   [mqmf_pkg::NUM_QUEUES];
  logic [mqmf_pkg::SW-1:0] read_slot    [mqmf_pkg::NUM_QUEUES];
  logic [mqmf_pkg::OW-1:0] write_offset [mqmf_pkg::NUM_QUEUES];
  logic [mqmf_pkg::OW-1:0] read_offset  [mqmf_pkg::NUM_QUEUES];
  logic                    dropping     [mqmf_pkg::NUM_QUEUES];
  logic                    overflowed   [mqmf_pkg::NUM_QUEUES];
  // Length of each queue's head message, refilled from the length store.
  logic [mqmf_pkg::OW-1:0] head_len     [mqmf_pkg::NUM_QUEUES];

  logic                    refill_pend;
  logic [mqmf_pkg::QW-1:0] refill_q;

  logic                    q_ok;
  logic [mqmf_pkg::QW-1:0] qi;
  logic [mqmf_pkg::SW-1:0] ws, rs, t, h, h_after;
  logic [mqmf_pkg::OW-1:0] wo, ro, off, len_cur;
  logic [mqmf_pkg::SW-1:0] write_slot_next, read_slot_next;
  logic [mqmf_pkg::OW-1:0] write_offset_next, read_offset_next;
  logic                    dropping_next, overflowed_next;
  logic                    set_head, do_refill;

  always_comb begin
    q_ok    = 32'(cmd.queue) < mqmf_pkg::NUM_QUEUES;
    qi      = cmd.queue[mqmf_pkg::QW-1:0];
    ws      = write_slot[qi];
    rs      = read_slot[qi];
    wo      = write_offset[qi];
    ro      = read_offset[qi];
    t       = (ws == mqmf_pkg::SW'(mqmf_pkg::SLOTS - 1)) ? '0 : ws + 1'b1;
    h       = (rs == mqmf_pkg::SW'(mqmf_pkg::SLOTS - 1)) ? '0 : rs + 1'b1;
    h_after = (h  == mqmf_pkg::SW'(mqmf_pkg::SLOTS - 1)) ? '0 : h + 1'b1;
    len_cur = (refill_pend && refill_q == qi) ? len_rdata : head_len[qi];
    off     = (ro >= mqmf_pkg::OW'(mqmf_pkg::MAX_BYTES)) ?
              mqmf_pkg::OW'(mqmf_pkg::MAX_BYTES - 1) : ro;

    write_slot_next   = ws;
    read_slot_next    = rs;
    write_offset_next = wo;
    read_offset_next  = ro;
    dropping_next     = dropping[qi];
    overflowed_next   = overflowed[qi];
    set_head          = 1'b0;
    do_refill         = 1'b0;

    byte_req       = '0;
    byte_req.wdata = cmd.data;
    byte_req.waddr = {qi, t, wo[mqmf_pkg::BW-1:0]};
    byte_req.raddr = {qi, h, off[mqmf_pkg::BW-1:0]};
    len_req        = '0;
    len_req.waddr  = {qi, t};
    len_req.raddr  = {qi, h_after};

    meta        = '0;
    meta.status = mqmf_pkg::ST_OK;

    unique case (cmd.op)
      mqmf_pkg::OP_WRITE: begin
        // A message whose first byte finds the ring full is dropped whole.
        if (dropping[qi] || (wo == '0 && t == rs)) begin
          meta.status   = mqmf_pkg::ST_FULL;
          dropping_next = !cmd.last;
        end else begin
          if (wo < mqmf_pkg::OW'(mqmf_pkg::MAX_BYTES)) begin
            byte_req.we       = 1'b1;
            write_offset_next = wo + 1'b1;
          end else begin
            overflowed_next = 1'b1;
          end
          meta.status = overflowed_next ? mqmf_pkg::ST_TRUNC : mqmf_pkg::ST_OK;
          if (cmd.last) begin
            len_req.we        = 1'b1;
            len_req.wdata     = write_offset_next;
            set_head          = (ws == rs);
            write_slot_next   = t;
            write_offset_next = '0;
            overflowed_next   = 1'b0;
          end
        end
      end
      mqmf_pkg::OP_READ: begin
        if (ws == rs) begin
          meta.status = mqmf_pkg::ST_EMPTY;
        end else begin
          byte_req.re      = 1'b1;
          meta.rd_byte     = 1'b1;
          meta.msg_len     = 8'(len_cur);
          read_offset_next = off + 1'b1;
          if (read_offset_next >= len_cur) begin
            // Free the slot and fetch the next head length.
            meta.end_of_msg  = 1'b1;
            read_slot_next   = h;
            read_offset_next = '0;
            do_refill        = 1'b1;
            len_req.re       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    meta.can_read = write_slot_next != read_slot_next;

    if (!q_ok) begin
      byte_req = '0;
      len_req  = '0;
      meta     = '0;
      meta.status = (cmd.op == mqmf_pkg::OP_WRITE) ? mqmf_pkg::ST_FULL :
                    (cmd.op == mqmf_pkg::OP_READ)  ? mqmf_pkg::ST_EMPTY : mqmf_pkg::ST_OK;
      set_head  = 1'b0;
      do_refill = 1'b0;
    end

    if (!accept) begin
      byte_req.we = 1'b0;
      byte_req.re = 1'b0;
      len_req.we  = 1'b0;
      len_req.re  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqmf_pkg::NUM_QUEUES; i++) begin
        write_slot[i]   <= '0;
        read_slot[i]    <= '0;
        write_offset[i] <= '0;
        read_offset[i]  <= '0;
        dropping[i]     <= 1'b0;
        overflowed[i]   <= 1'b0;
      end
      refill_pend <= 1'b0;
    end else begin
      refill_pend <= accept && do_refill;
      if (accept && q_ok) begin
        write_slot[qi]   <= write_slot_next;
        read_slot[qi]    <= read_slot_next;
        write_offset[qi] <= write_offset_next;
        read_offset[qi]  <= read_offset_next;
        dropping[qi]     <= dropping_next;
        overflowed[qi]   <= overflowed_next;
      end
    end
  end

  // Head lengths: land the refill, and let a commit into an empty ring win.
  always_ff @(posedge clk) begin
    refill_q <= qi;
    if (refill_pend) begin
      head_len[refill_q] <= len_rdata;
    end
    if (accept && set_head) begin
      head_len[qi] <= len_req.wdata;
    end
  end

endmodule

/* sv/multi_queue_message_fifo.sv */
// Top level of the multi-queue message FIFO: control, message stores and result stages.
//
// Usage: four independent rings of byte messages, each of up to 16 slots
// (one always spare) holding messages of up to 128 bytes.
// Command channel (cmd_valid / cmd_stall / cmd) carries one word per byte
// access: a write stores one message byte and commits the message on last,
// a read returns one byte of the head message and frees the slot on its
// final byte, a query reports whether the ring holds a complete message.
// Result channel (res_valid / res_stall / res) returns exactly one word per
// command word, in order.
// Pipeline: a command's result fields are registered in the middle stage, beside
// the registered read of the byte store, and then in the result register.
// Throughput: one word per cycle while cmd_stall is low, set by the single
// write and read port of each store and the per-queue index registers.
// Stall: while res_stall holds the result, one more command is still taken
// into the middle stage if it is empty; after that cmd_stall rises until the result moves.
// Reset: all rings start empty; stored bytes and lengths need no clearing.

module multi_queue_message_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  mqmf_pkg::cmd_t   cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output mqmf_pkg::res_t   res
);

  logic                       accept;
  mqmf_pkg::byte_req_t        byte_req;
  mqmf_pkg::len_req_t         len_req;
  mqmf_pkg::meta_t            meta;
  logic [7:0]                 byte_rdata;
  logic [mqmf_pkg::OW-1:0]    len_rdata;

  // Middle stage: result fields waiting for the byte store's read data.
  logic                       s1_valid;
  mqmf_pkg::meta_t            s1_meta;
  logic                       s1_move;

  assign s1_move   = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  mqmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .len_rdata (len_rdata),
    .byte_req  (byte_req),
    .len_req   (len_req),
    .meta      (meta)
  );

  // Message bytes; read only on an accepted read, so the data holds while stalled.
  mqmf_ram #(
    .WIDTH (8),
    .DEPTH (mqmf_pkg::BYTE_DEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_req.we),
    .waddr (byte_req.waddr),
    .wdata (byte_req.wdata),
    .re    (byte_req.re),
    .raddr (byte_req.raddr),
    .rdata (byte_rdata)
  );

  // Committed message lengths, read back to refill a ring's head length.
  mqmf_ram #(
    .WIDTH (mqmf_pkg::OW),
    .DEPTH (mqmf_pkg::LEN_DEPTH)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_req.we),
    .waddr (len_req.waddr),
    .wdata (len_req.wdata),
    .re    (len_req.re),
    .raddr (len_req.raddr),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Advance the middle stage when it drains or a new word arrives.
      s1_valid <= accept || (s1_valid && !s1_move);
      if (s1_move) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
    if (s1_move) begin
      res.status     <= s1_meta.status;
      res.data_out   <= s1_meta.rd_byte ? byte_rdata : 8'd0;
      res.msg_len    <= s1_meta.msg_len;
      res.end_of_msg <= s1_meta.end_of_msg;
      res.can_read   <= s1_meta.can_read;
    end
  end

endmodule

/* sv/mqmf_checker.sv */
// Port-level checks for the multi-queue message FIFO, bound to the top level.
module mqmf_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input mqmf_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_stall,
  input mqmf_pkg::res_t res
);

  // Hold a stalled result word.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Drop every result during reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown after reset");

  // Carry no byte, length or end mark on a word whose status is not OK.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != mqmf_pkg::ST_OK |->
      res.data_out == 8'd0 && res.msg_len == 8'd0 && !res.end_of_msg)
    else $error("read fields set on a failed word");

  // Hold a stalled command word.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("command word changed while stalled");

  // An empty answer leaves nothing to read.
  a_empty_unreadable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == mqmf_pkg::ST_EMPTY |-> !res.can_read)
    else $error("empty answer reports a readable queue");

endmodule

bind multi_queue_message_fifo mqmf_checker u_mqmf_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
